// File: rtl/tmtc_pkg.sv
// Shared constants, types and control structs for the three-channel trimmed-mean averager.
package tmtc_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 4;
    localparam int COUNT_BITS    = 8;
    localparam int AVG_BITS      = 20;
    localparam int NUM_CH        = 3;
    localparam int TRIM_COUNT    = 2;
    localparam int WINDOW_RESET  = 8;

    // The sum of up to 255 samples never wraps.
    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_BITS  = SUM_BITS + FRACTION_BITS;
    localparam int WIDE_BITS = (NUM_BITS > AVG_BITS) ? NUM_BITS : AVG_BITS;
    localparam int STEP_BITS = $clog2(NUM_BITS);

    localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

    typedef logic [SAMPLE_WIDTH-1:0] t_sample_in;
    typedef logic [SAMPLE_BITS-1:0]  t_sample;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [AVG_BITS-1:0]     t_avg;

    typedef enum logic [1:0] {
        S_ACCUM,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic acc;    // successful read: fold the sample in
        logic first;  // first successful read of the window
        logic start;  // load the divider
        logic step;   // one division step
    } t_lane_ctrl;

endpackage

// File: rtl/tmtc_in_if.sv
// Input channel: one read attempt per transaction.
interface tmtc_in_if
    import tmtc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       read_ok;
    t_sample_in pm1_sample;
    t_sample_in pm25_sample;
    t_sample_in pm10_sample;

    modport source (
        output valid, read_ok, pm1_sample, pm25_sample, pm10_sample,
        input  ready
    );

    modport sink (
        input  valid, read_ok, pm1_sample, pm25_sample, pm10_sample,
        output ready
    );
endinterface

// File: rtl/tmtc_out_if.sv
// Output channel: one averaged result per finished window.
interface tmtc_out_if
    import tmtc_pkg::*;
();
    logic   valid;
    logic   ready;
    t_avg   pm1_avg_x16;
    t_avg   pm25_avg_x16;
    t_avg   pm10_avg_x16;
    logic   got_reading;
    t_count good_reads;

    modport source (
        output valid, pm1_avg_x16, pm25_avg_x16, pm10_avg_x16, got_reading, good_reads,
        input  ready
    );

    modport sink (
        input  valid, pm1_avg_x16, pm25_avg_x16, pm10_avg_x16, got_reading, good_reads,
        output ready
    );
endinterface

// File: rtl/tmtc_lane.sv
// One channel lane: running min, max and sum, and a bit-serial restoring divider.
module tmtc_lane
    import tmtc_pkg::*;
(
    input  logic       i_clk,
    input  t_lane_ctrl i_ctrl,
    input  t_sample    i_sample,
    input  t_count     i_good,
    output t_avg       o_avg
);

    t_sample               r_min;
    t_sample               r_max;
    logic [SUM_BITS-1:0]   r_sum;
    logic [NUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS-1:0] r_rem;

    logic [COUNT_BITS-1:0] w_divisor;
    logic [SUM_BITS-1:0]   w_trimmed;
    logic [COUNT_BITS:0]   w_rem_sh;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_qbit;
    logic [WIDE_BITS-1:0]  w_wide;

    assign w_divisor = i_good - COUNT_BITS'(TRIM_COUNT);
    assign w_trimmed = r_sum - SUM_BITS'(r_min) - SUM_BITS'(r_max);
    assign w_rem_sh  = {r_rem, r_quo[NUM_BITS-1]};
    assign w_diff    = w_rem_sh - {1'b0, w_divisor};
    assign w_qbit    = (w_rem_sh >= {1'b0, w_divisor});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc) begin
            if (i_ctrl.first) begin
                r_min <= i_sample;
                r_max <= i_sample;
                r_sum <= SUM_BITS'(i_sample);
            end else begin
                if (i_sample < r_min) begin
                    r_min <= i_sample;
                end
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
                r_sum <= r_sum + SUM_BITS'(i_sample);
            end
        end
        if (i_ctrl.start) begin
            r_quo <= NUM_BITS'(w_trimmed) << FRACTION_BITS;
            r_rem <= '0;
        end else if (i_ctrl.step) begin
            // shift one dividend bit in, subtract when it fits
            if (w_qbit) begin
                r_rem <= w_diff[COUNT_BITS-1:0];
            end else begin
                r_rem <= w_rem_sh[COUNT_BITS-1:0];
            end
            r_quo <= {r_quo[NUM_BITS-2:0], w_qbit};
        end
    end

    always_comb begin
        if (i_good > COUNT_BITS'(TRIM_COUNT)) begin
            w_wide = WIDE_BITS'(r_quo);
        end else if (i_good == '0) begin
            w_wide = '0;
        end else begin
            w_wide = WIDE_BITS'(r_min) << FRACTION_BITS;
        end
        if (w_wide > WIDE_BITS'(AVG_MAX)) begin
            o_avg = AVG_MAX;
        end else begin
            o_avg = w_wide[AVG_BITS-1:0];
        end
    end

endmodule

// File: rtl/trimmed_mean_three_channel.sv
// Top level: window control, three channel lanes and the result register.
//
// Each input transaction is one read attempt; input ready stays high while a window
// fills. The attempt that completes a window starts a restoring division in all
// three lanes at once, one quotient bit per cycle over a 28-bit dividend (the widened
// sum with four fraction bits), so input ready stays low after that attempt through
// the load state, 28 division steps and the move of the result into the output
// register, longer if the previous result has not yet been taken. The output
// register lets the next window start filling while its result waits. window_size
// may be written between transactions; zero counts as one, and a value below the
// attempts already gathered ends the window at the next attempt.
module trimmed_mean_three_channel
    import tmtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    tmtc_in_if.sink           i_in,
    tmtc_out_if.source        o_out
);

    t_state                r_state, n_state;
    t_count                r_window;
    t_count                r_attempt;
    t_count                r_success;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_out_valid;
    t_avg                  r_avg [NUM_CH];
    t_count                r_good;

    logic       w_fire;
    logic       w_ok;
    logic       w_load;
    logic       w_last_step;
    logic       w_end;
    t_count     w_limit;
    t_count     w_attempt_inc;
    t_lane_ctrl w_ctrl;
    t_sample    w_sample [NUM_CH];
    t_avg       w_avg [NUM_CH];

    assign w_fire        = i_in.valid & i_in.ready;
    assign w_ok          = w_fire & i_in.read_ok;
    assign w_limit       = (r_window == '0) ? COUNT_BITS'(1) : r_window;
    assign w_attempt_inc = (r_attempt != '1) ? r_attempt + COUNT_BITS'(1) : r_attempt;
    assign w_end         = (w_attempt_inc >= w_limit);
    assign w_last_step   = (r_step == STEP_BITS'(NUM_BITS - 1));
    assign w_load        = (r_state == S_DONE) & (~r_out_valid | o_out.ready);

    assign w_ctrl.acc   = w_ok;
    assign w_ctrl.first = (r_success == '0);
    assign w_ctrl.start = (r_state == S_START);
    assign w_ctrl.step  = (r_state == S_DIV);

    assign w_sample[0] = i_in.pm1_sample[SAMPLE_BITS-1:0];
    assign w_sample[1] = i_in.pm25_sample[SAMPLE_BITS-1:0];
    assign w_sample[2] = i_in.pm10_sample[SAMPLE_BITS-1:0];

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        tmtc_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample (w_sample[g]),
            .i_good   (r_success),
            .o_avg    (w_avg[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        case (r_state)
            S_ACCUM: begin
                i_in.ready = 1'b1;
                if (w_fire && w_end) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_window    <= COUNT_BITS'(WINDOW_RESET);
            r_attempt   <= '0;
            r_success   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_attempt <= w_end ? '0 : w_attempt_inc;
            end
            if (w_ok && r_success != '1) begin
                r_success <= r_success + COUNT_BITS'(1);
            end else if (w_load) begin
                r_success <= '0;
            end
            // advance the division step counter
            if (r_state == S_START) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + STEP_BITS'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_avg <= w_avg;
            r_good <= r_success;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pm1_avg_x16  = r_avg[0];
    assign o_out.pm25_avg_x16 = r_avg[1];
    assign o_out.pm10_avg_x16 = r_avg[2];
    assign o_out.got_reading  = (r_good != '0);
    assign o_out.good_reads   = r_good;

    a_empty_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.got_reading) |->
            (o_out.pm1_avg_x16 == '0 && o_out.pm25_avg_x16 == '0 &&
             o_out.pm10_avg_x16 == '0))
        else $error("empty window gave a nonzero channel result");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step <= STEP_BITS'(NUM_BITS - 1)))
        else $error("division step counter ran past the dividend width");

    a_window_end_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_end) |=> (r_state == S_START && r_attempt == '0))
        else $error("window end did not start the division");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

endmodule
